// ===== hw/rtl/bbp_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the bitstream bit packer.
// No dependencies; used by bbp_word_store, bbp_out_fifo, bitstream_bit_packer_core and the testbench.
package bbp_pkg;

	localparam int WORD_BITS = 32;
	localparam int CNT_W     = 6;
	localparam int FILL_W    = 12;
	localparam int DIDX_W    = 6;
	localparam int IN_W      = 40;
	localparam int OUT_W     = 56;

	typedef struct packed {
		logic [DIDX_W-1:0]    done_index;
		logic [WORD_BITS-1:0] done_word;
		logic                 word_done;
		logic [FILL_W-1:0]    remaining_bits;
		logic                 accepted;
	} res_t;

endpackage

// ===== hw/rtl/bbp_word_store.sv =====
`timescale 1ns / 1ps
// Word store: single-port-write, single-port-read synchronous RAM, registered read.
// Depends on bbp_pkg for the word width.
module bbp_word_store #(
	parameter int DEPTH = 64,
	parameter int IDX_W = 6
) (
	input  logic                          clk,
	input  logic                          rd_en,
	input  logic [IDX_W-1:0]              rd_addr,
	output logic [bbp_pkg::WORD_BITS-1:0] rd_data,
	input  logic                          wr_en,
	input  logic [IDX_W-1:0]              wr_addr,
	input  logic [bbp_pkg::WORD_BITS-1:0] wr_data
);
	import bbp_pkg::*;

	logic [WORD_BITS-1:0] mem [DEPTH];

	// read-before-write on a same-address collision; caller forwards
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hw/rtl/bbp_out_fifo.sv =====
`timescale 1ns / 1ps
// Three-entry result buffer between the merge stage and the output stream.
// Depends on bbp_pkg (res_t, OUT_W).
module bbp_out_fifo (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      push,
	input  bbp_pkg::res_t             push_data,
	output logic [1:0]                level,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [bbp_pkg::OUT_W-1:0] m_tdata
);
	import bbp_pkg::*;

	localparam int DEPTH = 3;

	res_t       buf_q [DEPTH];
	logic [1:0] wptr_q;
	logic [1:0] rptr_q;
	logic [1:0] cnt_q;
	logic       pop;
	res_t       head;

	assign pop      = m_tvalid && m_tready;
	assign m_tvalid = (cnt_q != 2'd0);
	assign level    = cnt_q;
	assign head     = buf_q[rptr_q];
	assign m_tdata  = {4'b0, head.done_index, head.done_word, head.word_done,
		head.remaining_bits, head.accepted};

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 2'd0;
			rptr_q <= 2'd0;
			cnt_q  <= 2'd0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == 2'(DEPTH - 1)) ? 2'd0 : wptr_q + 2'd1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == 2'(DEPTH - 1)) ? 2'd0 : rptr_q + 2'd1;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== hw/rtl/bitstream_bit_packer_core.sv =====
`timescale 1ns / 1ps
// Bitstream bit packer top level: admission check, word store read-modify-write, result buffer.
// Depends on bbp_pkg, bbp_word_store, bbp_out_fifo.
//
//  channel  | dir | handshake        | payload (low bit up)
//  ---------+-----+------------------+-------------------------------------------------------
//  s_       | in  | s_tvalid/tready  | bit_count[5:0], bits_value[37:6], zero [39:38]
//  m_       | out | m_tvalid/tready  | accepted, remaining_bits, word_done, done_word,
//           |     |                  | done_index, zero [55:52]
//  cfg      | in  | cfg_wen          | capacity_bits[11:0]
//
// One push per cycle sustained while s_tready is high. The push is admitted at the input edge
// (fill count updated and word store read issued there), the merge runs in the next cycle and
// the result enters the three-entry buffer at the end of that cycle, where m_tvalid rises.
// A back-to-back push to the same word is served by forwarding the pending store write.
// Reset clears the fill count, capacity (to 2048) and buffer; the store needs no clearing
// pass because a word at offset zero is merged as zero and any other word was written before.
// s_tready drops only while the buffer plus the merge stage hold three results.
module bitstream_bit_packer_core #(
	parameter int STORE_WORDS = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [bbp_pkg::IN_W-1:0]  s_tdata,   // bit_count[5:0], bits_value[37:6]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [bbp_pkg::OUT_W-1:0] m_tdata,   // accepted[0], remaining_bits[12:1],
	                                             // word_done[13], done_word[45:14],
	                                             // done_index[51:46]
	input  logic                      cfg_wen,
	input  logic [bbp_pkg::FILL_W-1:0] cfg_wdata // capacity_bits
);
	import bbp_pkg::*;

	localparam int IDX_W    = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int STORE_B  = STORE_WORDS * WORD_BITS;
	localparam int CAP_LIM  = (STORE_B < 4095) ? STORE_B : 4095;

	// ---------------- configuration and fill state ----------------
	logic [FILL_W-1:0] capacity_q;
	logic [FILL_W-1:0] fill_q;
	logic [FILL_W-1:0] cap_eff;

	assign cap_eff = (capacity_q > FILL_W'(CAP_LIM)) ? FILL_W'(CAP_LIM) : capacity_q;

	// ---------------- input admission ----------------
	logic [CNT_W-1:0]     in_cnt;
	logic [WORD_BITS-1:0] in_val;
	logic                 in_xfer;
	logic [FILL_W:0]      in_sum;
	logic                 in_ok;
	logic [IDX_W-1:0]     rd_addr;

	assign in_cnt  = s_tdata[CNT_W-1:0];
	assign in_val  = s_tdata[CNT_W +: WORD_BITS];
	assign in_xfer = s_tvalid && s_tready;
	assign in_sum  = {1'b0, fill_q} + (FILL_W + 1)'(in_cnt);
	assign in_ok   = (in_cnt <= CNT_W'(WORD_BITS)) && (in_sum <= {1'b0, cap_eff});
	assign rd_addr = IDX_W'(fill_q[FILL_W-1:5]);

	// ---------------- merge stage registers ----------------
	logic                 valid_s1;
	logic                 acc_s1;
	logic [CNT_W-1:0]     cnt_s1;
	logic [WORD_BITS-1:0] val_s1;
	logic [4:0]           off_s1;     // bit offset inside the current word
	logic [6:0]           widx_s1;    // current word index
	logic [FILL_W-1:0]    fill_s1;    // fill after this push
	logic [FILL_W-1:0]    cap_s1;
	logic                 fwd_s1;
	logic [WORD_BITS-1:0] fwd_data_s1;

	// store write port (driven from the merge stage)
	logic                 st_we;
	logic [IDX_W-1:0]     st_waddr;
	logic [WORD_BITS-1:0] st_wdata;
	logic [WORD_BITS-1:0] st_rdata;

	logic [1:0] fifo_level;
	logic [2:0] occupancy;

	assign occupancy = {1'b0, fifo_level} + {2'b0, valid_s1};
	assign s_tready  = (occupancy < 3'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= FILL_W'(2048);
			fill_q     <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (cfg_wen) begin
				capacity_q <= cfg_wdata;
			end
			if (in_xfer && in_ok) begin
				fill_q <= in_sum[FILL_W-1:0];
			end
			valid_s1 <= in_xfer;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			acc_s1      <= in_ok;
			cnt_s1      <= in_cnt;
			val_s1      <= in_val;
			off_s1      <= fill_q[4:0];
			widx_s1     <= fill_q[FILL_W-1:5];
			fill_s1     <= in_ok ? in_sum[FILL_W-1:0] : fill_q;
			cap_s1      <= cap_eff;
			// the merge stage writes this entry at the same edge as the read
			fwd_s1      <= st_we && (st_waddr == rd_addr);
			fwd_data_s1 <= st_wdata;
		end
	end

	bbp_word_store #(
		.DEPTH(STORE_WORDS),
		.IDX_W(IDX_W)
	) u_store (
		.clk    (clk),
		.rd_en  (in_xfer),
		.rd_addr(rd_addr),
		.rd_data(st_rdata),
		.wr_en  (st_we),
		.wr_addr(st_waddr),
		.wr_data(st_wdata)
	);

	// ---------------- merge: insert bits, split at the word boundary ----------------
	logic [WORD_BITS-1:0] rev_val;
	logic [WORD_BITS-1:0] old_word;
	logic [CNT_W-1:0]     room;       // free bits in the current word, 1..32
	logic [CNT_W-1:0]     take;       // bits that land in the current word
	logic [CNT_W-1:0]     spill;      // bits that start the next word
	logic [WORD_BITS-1:0] cur_word;
	logic [WORD_BITS-1:0] next_word;
	logic                 done;
	logic [FILL_W-1:0]    remain;
	res_t                 res;

	// bit 0 of the value is the earliest bit, so it must sit highest
	always_comb begin
		for (int i = 0; i < WORD_BITS; i++) begin
			rev_val[WORD_BITS-1-i] = val_s1[i];
		end
	end

	// a word at offset zero is fresh and reads as zero
	assign old_word  = (off_s1 == 5'd0) ? '0 : (fwd_s1 ? fwd_data_s1 : st_rdata);
	assign room      = CNT_W'(WORD_BITS) - {1'b0, off_s1};
	assign take      = (cnt_s1 < room) ? cnt_s1 : room;
	assign spill     = cnt_s1 - take;
	assign cur_word  = (old_word << take) | (rev_val >> (CNT_W'(WORD_BITS) - take));
	assign next_word = (rev_val >> (CNT_W'(WORD_BITS) - cnt_s1))
		& ~({WORD_BITS{1'b1}} << spill);
	assign done      = acc_s1 && (cnt_s1 != '0) && (take == room);
	assign remain    = (fill_s1 >= cap_s1) ? '0 : cap_s1 - fill_s1;

	// a word finished with spill leaves only through the result
	assign st_we    = valid_s1 && acc_s1 && (cnt_s1 != '0);
	assign st_waddr = (spill != '0) ? IDX_W'(widx_s1 + 7'd1) : IDX_W'(widx_s1);
	assign st_wdata = (spill != '0) ? next_word : cur_word;

	always_comb begin
		res.accepted       = acc_s1;
		res.remaining_bits = remain;
		res.word_done      = done;
		res.done_word      = done ? cur_word : '0;
		res.done_index     = done ? widx_s1[DIDX_W-1:0] : '0;
	end

	bbp_out_fifo u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (valid_s1),
		.push_data(res),
		.level    (fifo_level),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// ---------------- assertions ----------------
	a_fill_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(CAP_LIM))
		else $error("fill count beyond store capacity");

	a_done_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && done) |-> acc_s1)
		else $error("word completed by a rejected push");

	a_xfer_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> valid_s1)
		else $error("accepted push lost before merge stage");

	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

endmodule

// ===== sim/tb_bitstream_bit_packer_core.sv =====
`timescale 1ns / 1ps
// Self-checking bench for bitstream_bit_packer_core: directed and random pushes under several
// capacity settings, with a bit-level packing predictor and in-order result checking.
// Depends on bbp_pkg and the packer RTL.
module tb_bitstream_bit_packer_core;

	import bbp_pkg::*;

	localparam int STORE_WORDS   = 64;
	localparam int STORE_BITS    = STORE_WORDS * WORD_BITS;
	localparam int N_ITEMS       = 1550;
	localparam int TAIL_ITEMS    = 150;   // last phase runs with the widest capacity
	localparam int SETTLE_CYCLES = 4;
	localparam int QUIET_LIMIT   = 2000;  // cycles with no transfer before giving up

	// Packing predictor plus expected-result queue.
	class pack_scoreboard;
		logic [FILL_W-1:0]    capacity;
		int unsigned          fill;
		logic [WORD_BITS-1:0] words [STORE_WORDS];
		res_t                 expected_q [$];
		int unsigned          errors;

		function new();
			capacity = 12'd2048;
			fill     = 0;
			errors   = 0;
			foreach (words[i]) words[i] = '0;
		endfunction

		// Capacity as the block enforces it: bounded by the store and the counter width.
		function int unsigned usable();
			int unsigned c;
			c = 32'(capacity);
			if (c > STORE_BITS) c = STORE_BITS;
			if (c > 4095) c = 4095;
			return c;
		endfunction

		function int unsigned room();
			return (fill >= usable()) ? 0 : usable() - fill;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Bits go in value bit 0 first, each shifted into bit 0 of the open word.
		function void note_push(logic [CNT_W-1:0] count, logic [WORD_BITS-1:0] value);
			res_t        r;
			int unsigned w;
			r = '0;
			if (32'(count) <= WORD_BITS && fill + 32'(count) <= usable()) begin
				r.accepted = 1'b1;
				for (int i = 0; i < int'(count); i++) begin
					w = fill >> 5;
					if (w < STORE_WORDS) begin
						words[w] = {words[w][WORD_BITS-2:0], value[i]};
						fill     = (fill + 1) & 12'hFFF;
						if (fill % WORD_BITS == 0) begin
							r.word_done  = 1'b1;
							r.done_word  = words[w];
							r.done_index = w[DIDX_W-1:0];
						end
					end
				end
			end
			r.remaining_bits = FILL_W'(room());
			expected_q.push_back(r);
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with no push outstanding, got %h", $time, got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.accepted !== want.accepted) begin
				$display("%0t: accepted expected %0d got %0d", $time, want.accepted, got.accepted);
				errors++;
			end
			if (got.remaining_bits !== want.remaining_bits) begin
				$display("%0t: remaining_bits expected %0d got %0d", $time,
					want.remaining_bits, got.remaining_bits);
				errors++;
			end
			if (got.word_done !== want.word_done) begin
				$display("%0t: word_done expected %0d got %0d", $time,
					want.word_done, got.word_done);
				errors++;
			end
			if (got.done_word !== want.done_word) begin
				$display("%0t: done_word expected %h got %h", $time,
					want.done_word, got.done_word);
				errors++;
			end
			if (got.done_index !== want.done_index) begin
				$display("%0t: done_index expected %0d got %0d", $time,
					want.done_index, got.done_index);
				errors++;
			end
		endfunction
	endclass

	logic              clk;
	logic              arst_n    = 1'b0;
	logic              s_tvalid  = 1'b0;
	logic              s_tready;
	logic [IN_W-1:0]   s_tdata   = '0;  // bit_count[5:0], bits_value[37:6]
	logic              m_tvalid;
	logic              m_tready  = 1'b0;
	logic [OUT_W-1:0]  m_tdata;         // accepted, remaining_bits, word_done, done_word,
	                                    // done_index
	logic              cfg_wen   = 1'b0;
	logic [FILL_W-1:0] cfg_wdata = '0;  // capacity_bits

	pack_scoreboard sb;
	bit             idle_on = 1'b1;
	int unsigned    sent    = 0;
	int unsigned    quiet   = 0;

	bitstream_bit_packer_core #(
		.STORE_WORDS(STORE_WORDS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Result side: random back-pressure, none during the phases with no idling.
	always @(posedge clk) begin
		m_tready <= !(idle_on && $urandom_range(0, 99) < 23);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(res_t'(m_tdata[51:0]));
	end

	// Watchdog: any transfer or register write restarts the count.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// One push; an optional gap before it, prediction at the accepting edge.
	// Each idle cycle is followed by another idle cycle with the same odds as the first.
	task automatic push_bits(input logic [CNT_W-1:0] count, input logic [WORD_BITS-1:0] value);
		if (idle_on && $urandom_range(0, 99) < 23) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(0, 99) < 23);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {2'b00, value, count};
		do @(posedge clk); while (!s_tready);
		sb.note_push(count, value);
		sent++;
	endtask

	// Stop sending and let every outstanding result drain out.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_capacity(input logic [FILL_W-1:0] value);
		settle();
		cfg_wen   <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_wen   <= 1'b0;
		sb.capacity = value;
	endtask

	// Mostly pushes that fit the remaining room, some that fill it exactly,
	// the rest oversized or over-count noise.
	task automatic random_push();
		int unsigned          room;
		int unsigned          lim;
		int unsigned          pick;
		logic [CNT_W-1:0]     count;
		logic [WORD_BITS-1:0] value;
		room = sb.room();
		lim  = (room > WORD_BITS) ? WORD_BITS : room;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			count = CNT_W'($urandom_range(0, lim));
		else if (pick < 70)
			count = CNT_W'(lim);
		else if (pick < 85)
			count = CNT_W'($urandom_range(0, WORD_BITS));
		else
			count = CNT_W'($urandom_range(33, 63));
		pick = $urandom_range(0, 19);
		if (pick == 0)
			value = '0;
		else if (pick == 1)
			value = '1;
		else
			value = $urandom();
		push_bits(count, value);
	endtask

	initial begin
		logic [FILL_W-1:0] cap;
		int unsigned       pick;
		int unsigned       phase;
		int unsigned       phase_len;

		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset capacity: an empty push sees the full 2048 bits of room.
		push_bits(6'd0, 32'd0);

		// Zero capacity: only an empty push fits.
		set_capacity(12'd0);
		push_bits(6'd0, 32'hFFFF_FFFF);
		push_bits(6'd1, 32'h1);
		push_bits(6'd33, 32'hFFFF_FFFF);

		// Capacity above the store is clamped to the store size.
		set_capacity(12'hFFF);
		push_bits(6'd32, 32'hFFFF_FFFF);
		push_bits(6'd32, 32'h0000_0000);
		push_bits(6'd63, $urandom());
		push_bits(6'd33, 32'h8000_0001);
		push_bits(6'd1, 32'h1);
		push_bits(6'd31, 32'h5555_5555);  // finishes the third word
		push_bits(6'd20, 32'h000A_BCDE);
		push_bits(6'd20, 32'h0001_2345);  // crosses a word boundary
		push_bits(6'd0, 32'hFFFF_FFFF);
		push_bits(6'd3, 32'h5);           // consecutive pushes into the same word
		push_bits(6'd5, 32'h1A);

		// Capacity dropped below the fill: even an empty push is turned away.
		set_capacity(12'd100);
		push_bits(6'd0, 32'd0);
		push_bits(6'd5, 32'h1F);

		// Room of exactly ten bits, then full.
		set_capacity(FILL_W'(sb.fill + 10));
		push_bits(6'd10, 32'h3FF);
		push_bits(6'd0, 32'd0);
		push_bits(6'd1, 32'd1);

		// Random phases, each under a fresh capacity; a run of phases with no idling.
		phase = 0;
		while (sent < N_ITEMS - TAIL_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick == 0)
				cap = FILL_W'($urandom_range(0, 4095));
			else if (pick == 1)
				cap = FILL_W'(sb.fill);
			else if (pick == 2 && sb.fill > 0)
				cap = FILL_W'($urandom_range(0, sb.fill - 1));
			else
				cap = FILL_W'(sb.fill + $urandom_range(0, 120));
			set_capacity(cap);
			idle_on   = !(phase >= 6 && phase < 12);
			phase_len = $urandom_range(20, 60);
			repeat (phase_len) random_push();
			phase++;
		end
		idle_on = 1'b1;
		set_capacity(12'hFFF);
		repeat (TAIL_ITEMS) random_push();

		settle();
		if (sb.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
